[rtl/gnc_pkg.sv]
// ============================================================================
// gnc_pkg
// Shared types, constants and a magnitude function for the gradient norm clipper.
// ============================================================================
package gnc_pkg;

    localparam int GRAD_COUNT = 4096;
    localparam int IDX_W      = 12;
    localparam int VAL_W      = 32;
    localparam int NORM_W     = 31;
    localparam int SUM_W      = 63;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Magnitude of a signed Q8.24 value (the most negative code maps to 2^31).
    function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] raw);
        logic [VAL_W-1:0] m;
        m = raw[VAL_W-1] ? (~raw + 32'd1) : raw;
        return m;
    endfunction

endpackage

[rtl/gradient_norm_clipper.sv]
// ============================================================================
// gradient_norm_clipper
// Global L2-norm gradient clipping over a 4096-entry gradient store.
// ============================================================================
// Sequence: a write, no-op or unclipped read passes through a store read, the
// square update and a bit-serial square root; a clipped read adds the
// divider and a multiply, and a clear first makes a pass over the whole store.
// One item in flight: a new input beat is taken only once the last output
// beat has been taken, so output stalls hold off the input.
// Reset: a clearing pass over all 4096 entries zeroes the store; the threshold is 1.0.
module gradient_norm_clipper
    import gnc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // command[1:0], index[13:2], grad_value[45:14]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // read_value[31:0], norm[62:32], clipped[63]
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FETCH, ST_SQ, ST_SUM, ST_ROOT, ST_DIV,
        ST_MUL, ST_OUT
    } state_t;

    state_t            state_reg;
    logic [NORM_W-1:0] clip_limit_reg;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [1:0]        cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [VAL_W-1:0]  stored_reg;
    logic [NORM_W-1:0] norm_reg;
    logic [55:0]       prod_reg;
    logic [VAL_W-1:0]  rd_reg;
    logic              clip_reg;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [VAL_W-1:0]  mem_wdata, mem_rdata;
    logic              sq_start, sq_done, dv_start, dv_done;
    logic [NORM_W-1:0] sq_root;
    logic [23:0]       dv_quot;
    logic [VAL_W-1:0]  old_mag, new_mag;
    logic [63:0]       old_sq, new_sq;
    logic              clip_now;

    assign old_mag  = mag_of(mem_rdata);
    assign new_mag  = mag_of(val_reg);
    assign old_sq   = old_mag * old_mag;
    assign new_sq   = new_mag * new_mag;
    assign clip_now = sq_root > clip_limit_reg;

    // Store ports: clearing pass or write-back.
    always_comb
    begin
        mem_we    = (state_reg == ST_CLEAR)
                  || (state_reg == ST_SUM && cmd_reg == CMD_WRITE);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_idx_reg : idx_reg;
        mem_wdata = (state_reg == ST_CLEAR) ? '0 : val_reg;
        mem_raddr = idx_reg;
    end

    gnc_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign sq_start = (state_reg == ST_SUM);
    gnc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign dv_start = (state_reg == ST_ROOT) && sq_done && clip_now
                      && cmd_reg == CMD_READ;
    gnc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (clip_limit_reg),
        .den   (sq_root),
        .done  (dv_done),
        .quot  (dv_quot)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_limit_reg <= 31'd65536;
        end
        else if (cfg_we)
        begin
            clip_limit_reg <= cfg_wdata;
        end
    end

    // Command sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            sum_reg     <= '0;
            cmd_reg     <= CMD_NOP;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == IDX_W'(GRAD_COUNT - 1))
                    begin
                        state_reg <= (cmd_reg == CMD_CLEAR) ? ST_SUM : ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cmd_reg   <= s_axis_tdata[1:0];
                        idx_reg   <= s_axis_tdata[13:2];
                        val_reg   <= s_axis_tdata[45:14];
                        if (s_axis_tdata[1:0] == CMD_CLEAR)
                        begin
                            sum_reg   <= '0;
                            state_reg <= ST_CLEAR;
                        end
                        else
                        begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    stored_reg <= mem_rdata;
                    state_reg  <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (sq_done)
                    begin
                        norm_reg <= sq_root;
                        clip_reg <= clip_now;
                        if (cmd_reg == CMD_READ && clip_now)
                        begin
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            rd_reg    <= (cmd_reg == CMD_READ) ? stored_reg : '0;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (dv_done)
                    begin
                        prod_reg  <= mag_of(stored_reg) * dv_quot;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    rd_reg    <= stored_reg[VAL_W-1] ? (32'd0 - prod_reg[55:24])
                                                     : prod_reg[55:24];
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // Running sum update, done as the new square is ready.
            if (state_reg == ST_SQ && cmd_reg == CMD_WRITE)
            begin
                sum_reg <= SUM_W'(sum_reg - old_sq[63:16] + new_sq[63:16]);
            end
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {clip_reg, norm_reg, rd_reg};

endmodule

[rtl/gnc_store.sv]
// ============================================================================
// gnc_store
// Gradient store: one synchronous RAM with registered read data.
// ============================================================================
module gnc_store
    import gnc_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [VAL_W-1:0] wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem [GRAD_COUNT];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/gnc_sqrt.sv]
// ============================================================================
// gnc_sqrt
// Bit-serial integer square root of the 63-bit sum, one result bit a cycle.
// ============================================================================
module gnc_sqrt
    import gnc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  radicand,
    output logic              done,
    output logic [NORM_W-1:0] root
);

    logic [SUM_W:0]   rem_reg;
    logic [31:0]      res_reg;
    logic [SUM_W:0]   val_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic [SUM_W:0]   trial;
    logic [SUM_W+1:0] rem_sh;

    // Shift in two radicand bits, try subtracting 4*res+1.
    // The remainder stays below 2^34, so its top bit is always zero.
    always_comb
    begin
        rem_sh = {rem_reg[SUM_W-1:0], val_reg[SUM_W:SUM_W-1]};
        trial  = {30'd0, res_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                res_reg  <= '0;
                val_reg  <= {1'b0, radicand};
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                val_reg <= {val_reg[SUM_W-2:0], 2'b00};
                if (rem_sh >= {1'b0, trial})
                begin
                    rem_reg <= rem_sh[SUM_W:0] - trial;
                    res_reg <= {res_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[SUM_W:0];
                    res_reg <= {res_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // Saturate to the 31-bit norm range.
    assign root = res_reg[31] ? {NORM_W{1'b1}} : res_reg[NORM_W-1:0];

endmodule

[rtl/gnc_div.sv]
// ============================================================================
// gnc_div
// Restoring divider: floor(limit * 2^24 / norm), one quotient bit a cycle.
// ============================================================================
module gnc_div
    import gnc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NORM_W-1:0] num,
    input  logic [NORM_W-1:0] den,
    output logic              done,
    output logic [23:0]       quot
);

    // The quotient is below 2^24 since num < den, so 24 steps suffice.
    logic [NORM_W:0]   rem_reg;
    logic [23:0]       q_reg;
    logic [NORM_W-1:0] den_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic [NORM_W+1:0] rem_sh;

    assign rem_sh = {rem_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rem_reg  <= {1'b0, num};
                den_reg  <= den;
                q_reg    <= '0;
                cnt_reg  <= 5'd24;
            end
            else if (busy_reg)
            begin
                if (rem_sh >= {2'b00, den_reg})
                begin
                    rem_reg <= (NORM_W+1)'(rem_sh - {2'b00, den_reg});
                    q_reg   <= {q_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[NORM_W:0];
                    q_reg   <= {q_reg[22:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quot = q_reg;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Gradient norm clipper testbench
// Drives write, read, clear and no-op commands through the input stream,
// predicts every output beat from a local copy of the store, the sum of
// squares and the threshold, and compares each output beat field by field.
// ----------------------------------------------------------------------------
module tb_top
    import gnc_pkg::*;
();

    // Predicted output beat.
    typedef struct packed {
        logic [31:0] read_value;
        logic [30:0] norm;
        logic        clipped;
    } clip_result_t;

    // Clipping predictor and store of expected output beats.
    class clip_scoreboard;
        logic [31:0]  grad_mem [GRAD_COUNT];
        logic [62:0]  sum_sq;
        logic [30:0]  threshold;
        clip_result_t pending [$];
        int           errors;

        function new();
            foreach (grad_mem[i])
                grad_mem[i] = '0;
            sum_sq = '0;
            threshold = 31'd65536;
            errors = 0;
        endfunction

        function logic [63:0] magnitude(logic [31:0] raw);
            logic [63:0] m;
            m = raw[31] ? {32'd0, 32'd0 - raw} : {32'd0, raw};
            return m;
        endfunction

        function logic [62:0] square_q32(logic [31:0] raw);
            logic [63:0] m;
            logic [63:0] p;
            m = magnitude(raw);
            p = m * m;
            return p[62:0] >> 16;
        endfunction

        function logic [30:0] root_of_sum();
            logic [63:0] v;
            logic [63:0] res;
            logic [63:0] b;
            v = {1'b0, sum_sq};
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            if (res > 64'h7FFF_FFFF)
                res = 64'h7FFF_FFFF;
            return res[30:0];
        endfunction

        // Note an accepted input beat and queue its expected result.
        function void note_command(cmd_t cmd, logic [11:0] idx, logic [31:0] val);
            clip_result_t r;
            logic [63:0] scale;
            logic [63:0] mag;
            logic [63:0] q;
            logic [31:0] raw;
            r = '0;
            if (cmd == CMD_WRITE)
            begin
                sum_sq = sum_sq - square_q32(grad_mem[idx]) + square_q32(val);
                grad_mem[idx] = val;
            end
            else if (cmd == CMD_CLEAR)
            begin
                foreach (grad_mem[i])
                    grad_mem[i] = '0;
                sum_sq = '0;
            end
            r.norm = root_of_sum();
            r.clipped = r.norm > threshold;
            if (cmd == CMD_READ)
            begin
                raw = grad_mem[idx];
                if (r.clipped)
                begin
                    scale = ({33'd0, threshold} << 24) / {33'd0, r.norm};
                    mag = magnitude(raw);
                    q = (mag * scale) >> 24;
                    r.read_value = raw[31] ? 32'd0 - q[31:0] : q[31:0];
                end
                else
                    r.read_value = raw;
            end
            pending.push_back(r);
        endfunction

        // Compare one output beat with the oldest expectation.
        function void check_result(logic [63:0] data);
            clip_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected output beat %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.read_value)
            begin
                $error("read_value expected %h actual %h", e.read_value, data[31:0]);
                errors++;
            end
            if (data[62:32] !== e.norm)
            begin
                $error("norm expected %h actual %h", e.norm, data[62:32]);
                errors++;
            end
            if (data[63] !== e.clipped)
            begin
                $error("clipped expected %b actual %b", e.clipped, data[63]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        cfg_we;
    logic [30:0] cfg_wdata;

    clip_scoreboard sb;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    longint      cycle_count;

    gradient_norm_clipper u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock generation.
    initial
        clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit counter.
    initial
        cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 30_000_000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial
        m_axis_tready = 1'b0;
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Send one input beat, idling at random before it.
    task automatic send_beat(cmd_t cmd, logic [11:0] idx, logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, val, idx, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_command(cmd, idx, val);
    endtask

    // Wait until every expected beat has arrived, plus the block's latency.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    task automatic write_threshold(logic [30:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.threshold = value;
    endtask

    // Random value: mostly moderate, sometimes any 32-bit pattern.
    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(32'h0100_0000);
            2: v = 32'd0 - $urandom_range(32'h0100_0000);
            default: v = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
        endcase
        return v;
    endfunction

    // Mostly writes and reads on a small index window; rare clears.
    task automatic random_phase(int count);
        int   k;
        int   sel;
        cmd_t cmd;
        logic [11:0] idx;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(199);
            if (sel < 90)
                cmd = CMD_WRITE;
            else if (sel < 185)
                cmd = CMD_READ;
            else if (sel < 196)
                cmd = CMD_NOP;
            else
                cmd = CMD_CLEAR;
            idx = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
            send_beat(cmd, idx, $urandom_range(7) == 0 ? 32'($urandom) : rand_value());
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every command, out-of-window index.
        send_beat(CMD_READ, 12'd0, 32'd0);
        send_beat(CMD_WRITE, 12'd0, 32'h8000_0000);
        send_beat(CMD_WRITE, 12'd4095, 32'h7FFF_FFFF);
        send_beat(CMD_READ, 12'd0, 32'hFFFF_FFFF);
        send_beat(CMD_READ, 12'd4095, 32'd0);
        send_beat(CMD_NOP, 12'd4095, 32'hFFFF_FFFF);
        send_beat(CMD_WRITE, 12'd0, 32'h0100_0000);
        send_beat(CMD_READ, 12'd0, 32'd0);
        send_beat(CMD_WRITE, 12'd4095, 32'd0);
        send_beat(CMD_READ, 12'd0, 32'd0);
        send_beat(CMD_WRITE, 12'd5, 32'hFF00_0000);
        send_beat(CMD_READ, 12'd5, 32'd0);
        send_beat(CMD_CLEAR, 12'hABC, 32'h1234_5678);
        send_beat(CMD_READ, 12'd5, 32'd0);
        // Zero threshold: every nonzero norm clips to zero.
        write_threshold(31'd0);
        send_beat(CMD_WRITE, 12'd1, 32'h0000_0100);
        send_beat(CMD_READ, 12'd1, 32'd0);
        // Largest threshold: nothing clips.
        write_threshold(31'h7FFF_FFFF);
        send_beat(CMD_WRITE, 12'd2, 32'h8000_0000);
        send_beat(CMD_READ, 12'd2, 32'd0);
        write_threshold(31'd65536);

        // Receiver idles more than sender.
        send_idle_pct = 30;
        recv_idle_pct = 74;
        random_phase(400);
        write_threshold(31'($urandom_range(32'h0002_0000)));

        // Receiver holds off while the sender keeps offering beats.
        fork
            begin
                hold_off = 1'b1;
                repeat (2000)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(20);
        join

        // Sender idles more than receiver.
        send_idle_pct = 74;
        recv_idle_pct = 30;
        random_phase(400);
        write_threshold(31'($urandom_range(32'h0010_0000)));

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(460);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[filelist.f]
rtl/gnc_pkg.sv
rtl/gnc_store.sv
rtl/gnc_sqrt.sv
rtl/gnc_div.sv
rtl/gradient_norm_clipper.sv
dv/tb_top.sv
